### rtl/md2vh_pkg.sv
// Shared types, constants and the substitution table of the MD2-style digest block.
`timescale 1ns / 1ps

package md2vh_pkg;

    // Rounds over the work array per compression
    localparam int ROUNDS = 18;
    localparam int RND_W  = $clog2(ROUNDS);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic wr_byte;  // store the accepted byte at the fill position
        logic pad;      // fill the rest of the block with the pad value
        logic load;     // build the work array from state and block
        logic sel_cks;  // take the checksum as the block on load
        logic step;     // one serial table step over the work array
        logic commit;   // copy work bytes to state, prime checksum pass
        logic ck_step;  // one checksum step
        logic digest;   // hand state to the output buffer, clear for next message
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fill_last;   // next byte completes the block
        logic round_done;  // last step of the last round
        logic ck_done;     // last checksum step
        logic out_free;    // output buffer has been drained
    } t_dp_status;

    localparam logic [7:0] SBOX [256] = '{
        8'hbd,8'h56,8'hea,8'hf2,8'ha2,8'hf1,8'hac,8'h2a,
        8'hb0,8'h93,8'hd1,8'h9c,8'h1b,8'h33,8'hfd,8'hd0,
        8'h30,8'h04,8'hb6,8'hdc,8'h7d,8'hdf,8'h32,8'h4b,
        8'hf7,8'hcb,8'h45,8'h9b,8'h31,8'hbb,8'h21,8'h5a,
        8'h41,8'h9f,8'he1,8'hd9,8'h4a,8'h4d,8'h9e,8'hda,
        8'ha0,8'h68,8'h2c,8'hc3,8'h27,8'h5f,8'h80,8'h36,
        8'h3e,8'hee,8'hfb,8'h95,8'h1a,8'hfe,8'hce,8'ha8,
        8'h34,8'ha9,8'h13,8'hf0,8'ha6,8'h3f,8'hd8,8'h0c,
        8'h78,8'h24,8'haf,8'h23,8'h52,8'hc1,8'h67,8'h17,
        8'hf5,8'h66,8'h90,8'he7,8'he8,8'h07,8'hb8,8'h60,
        8'h48,8'he6,8'h1e,8'h53,8'hf3,8'h92,8'ha4,8'h72,
        8'h8c,8'h08,8'h15,8'h6e,8'h86,8'h00,8'h84,8'hfa,
        8'hf4,8'h7f,8'h8a,8'h42,8'h19,8'hf6,8'hdb,8'hcd,
        8'h14,8'h8d,8'h50,8'h12,8'hba,8'h3c,8'h06,8'h4e,
        8'hec,8'hb3,8'h35,8'h11,8'ha1,8'h88,8'h8e,8'h2b,
        8'h94,8'h99,8'hb7,8'h71,8'h74,8'hd3,8'he4,8'hbf,
        8'h3a,8'hde,8'h96,8'h0e,8'hbc,8'h0a,8'hed,8'h77,
        8'hfc,8'h37,8'h6b,8'h03,8'h79,8'h89,8'h62,8'hc6,
        8'hd7,8'hc0,8'hd2,8'h7c,8'h6a,8'h8b,8'h22,8'ha3,
        8'h5b,8'h05,8'h5d,8'h02,8'h75,8'hd5,8'h61,8'he3,
        8'h18,8'h8f,8'h55,8'h51,8'had,8'h1f,8'h0b,8'h5e,
        8'h85,8'he5,8'hc2,8'h57,8'h63,8'hca,8'h3d,8'h6c,
        8'hb4,8'hc5,8'hcc,8'h70,8'hb2,8'h91,8'h59,8'h0d,
        8'h47,8'h20,8'hc8,8'h4f,8'h58,8'he0,8'h01,8'he2,
        8'h16,8'h38,8'hc4,8'h6f,8'h3b,8'h0f,8'h65,8'h46,
        8'hbe,8'h7e,8'h2d,8'h7b,8'h82,8'hf9,8'h40,8'hb5,
        8'h1d,8'h73,8'hf8,8'heb,8'h26,8'hc7,8'h87,8'h97,
        8'h25,8'h54,8'hb1,8'h28,8'haa,8'h98,8'h9d,8'ha5,
        8'h64,8'h6d,8'h7a,8'hd4,8'h10,8'h81,8'h44,8'hef,
        8'h49,8'hd6,8'hae,8'h2e,8'hdd,8'h76,8'h5c,8'h2f,
        8'ha7,8'h1c,8'hc9,8'h09,8'h69,8'h9a,8'h83,8'hcf,
        8'h29,8'h39,8'hb9,8'he9,8'h4c,8'hff,8'h43,8'hab
    };

    // Substitution table lookup
    function automatic logic [7:0] sbox(input logic [7:0] a);
        return SBOX[a];
    endfunction

endpackage

### rtl/md2vh_ctrl.sv
// Sequencer for byte intake, padding, compression rounds, checksum and digest hand-off.
`timescale 1ns / 1ps

module md2vh_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_present,
    input  logic                  i_in_end,
    output logic                  o_in_ready,
    input  md2vh_pkg::t_dp_status i_status,
    output md2vh_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PAD    = 7'b0000010,
        S_LOAD   = 7'b0000100,
        S_ROUND  = 7'b0001000,
        S_COMMIT = 7'b0010000,
        S_CKSUM  = 7'b0100000,
        S_DIGEST = 7'b1000000
    } t_state;

    // Which block is being compressed
    typedef enum logic [1:0] {
        K_DATA  = 2'd0,
        K_PAD   = 2'd1,
        K_FINAL = 2'd2
    } t_kind;

    t_state r_state, n_state;
    t_kind  r_kind,  n_kind;
    logic   r_end,   n_end;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_end   = r_end;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.wr_byte = i_in_present;
                    n_end         = i_in_end;
                    if (i_in_present && i_status.fill_last) begin
                        n_kind  = K_DATA;
                        n_state = S_LOAD;
                    end else if (i_in_end) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.pad = 1'b1;
                n_kind    = K_PAD;
                n_state   = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load    = 1'b1;
                o_cmd.sel_cks = (r_kind == K_FINAL);
                n_state       = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.step = 1'b1;
                if (i_status.round_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = (r_kind == K_FINAL) ? S_DIGEST : S_CKSUM;
            end
            S_CKSUM: begin
                o_cmd.ck_step = 1'b1;
                if (i_status.ck_done) begin
                    if (r_kind == K_DATA) begin
                        n_state = r_end ? S_PAD : S_IDLE;
                    end else begin
                        n_kind  = K_FINAL;
                        n_state = S_LOAD;
                    end
                end
            end
            S_DIGEST: begin
                if (i_status.out_free) begin
                    o_cmd.digest = 1'b1;
                    n_end        = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_DATA;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_end   <= n_end;
        end
    end

endmodule

### rtl/md2vh_dp.sv
// Datapath: block buffer, rotating work array, chaining state, checksum and digest output.
`timescale 1ns / 1ps

module md2vh_dp #(
    parameter int BLOCK_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  md2vh_pkg::t_dp_cmd    i_cmd,
    output md2vh_pkg::t_dp_status o_status,
    input  logic [7:0]            i_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_out_last
);

    localparam int WORK_BYTES = 3 * BLOCK_BYTES;
    localparam int FILL_W     = $clog2(BLOCK_BYTES);
    localparam int POS_W      = $clog2(WORK_BYTES);
    localparam int RND_W      = md2vh_pkg::RND_W;

    logic [BLOCK_BYTES-1:0][7:0] r_buf;
    logic [BLOCK_BYTES-1:0][7:0] r_state;
    logic [BLOCK_BYTES-1:0][7:0] r_cks;
    logic [WORK_BYTES-1:0][7:0]  r_work;
    logic [BLOCK_BYTES-1:0][7:0] r_out_buf;
    logic [FILL_W-1:0]           r_fill;
    logic [FILL_W-1:0]           r_ck_idx;
    logic [FILL_W-1:0]           r_out_cnt;
    logic [POS_W-1:0]            r_pos;
    logic [RND_W-1:0]            r_rnd;
    logic [7:0]                  r_carry;
    logic [7:0]                  r_ck_carry;
    logic                        r_out_valid;

    logic [BLOCK_BYTES-1:0][7:0] w_blk;
    logic [7:0]                  w_pad_val;
    logic [7:0]                  w_idx;
    logic [7:0]                  w_work_new;
    logic [7:0]                  w_ck_new;
    logic                        w_pos_last;
    logic                        w_out_take;

    // Status toward the controller
    assign w_pos_last          = (r_pos == POS_W'(WORK_BYTES - 1));
    assign o_status.fill_last  = (r_fill == FILL_W'(BLOCK_BYTES - 1));
    assign o_status.round_done = w_pos_last && (r_rnd == RND_W'(md2vh_pkg::ROUNDS - 1));
    assign o_status.ck_done    = (r_ck_idx == FILL_W'(BLOCK_BYTES - 1));
    assign o_status.out_free   = !r_out_valid;

    // Serial step values
    assign w_blk      = i_cmd.sel_cks ? r_cks : r_buf;
    assign w_pad_val  = 8'(BLOCK_BYTES) - 8'(r_fill);
    assign w_idx      = 8'(WORK_BYTES) - 8'(r_pos) + r_carry;
    assign w_work_new = r_work[0] ^ md2vh_pkg::sbox(w_idx);
    assign w_ck_new   = r_cks[0] ^ md2vh_pkg::sbox(r_buf[r_ck_idx] ^ r_ck_carry);

    // Block buffer: byte writes and padding
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            r_buf[r_fill] <= i_byte;
        end else if (i_cmd.pad) begin
            for (int k = 0; k < BLOCK_BYTES; k++) begin
                if (FILL_W'(k) >= r_fill) begin
                    r_buf[k] <= w_pad_val;
                end
            end
        end
    end

    // Work array: load, then rotate one byte per step so each position meets the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work  <= {r_state ^ w_blk, w_blk, r_state};
            r_carry <= 8'h00;
        end else if (i_cmd.step) begin
            r_work  <= {w_work_new, r_work[WORK_BYTES-1:1]};
            r_carry <= w_work_new;
        end
    end

    // Checksum carry
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ck_carry <= r_cks[BLOCK_BYTES-1];
        end else if (i_cmd.ck_step) begin
            r_ck_carry <= w_ck_new;
        end
    end

    // Counters, state and checksum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_pos    <= '0;
            r_rnd    <= '0;
            r_ck_idx <= '0;
            r_state  <= '0;
            r_cks    <= '0;
        end else begin
            if (i_cmd.wr_byte) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (i_cmd.pad || i_cmd.digest) begin
                r_fill <= '0;
            end
            if (i_cmd.load) begin
                r_pos <= '0;
                r_rnd <= '0;
            end else if (i_cmd.step) begin
                if (w_pos_last) begin
                    r_pos <= '0;
                    r_rnd <= r_rnd + RND_W'(1);
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
            if (i_cmd.commit) begin
                r_state  <= r_work[BLOCK_BYTES-1:0];
                r_ck_idx <= '0;
            end else if (i_cmd.digest) begin
                r_state <= '0;
            end
            if (i_cmd.ck_step) begin
                r_cks    <= {w_ck_new, r_cks[BLOCK_BYTES-1:1]};
                r_ck_idx <= r_ck_idx + FILL_W'(1);
            end else if (i_cmd.digest) begin
                r_cks <= '0;
            end
        end
    end

    // Digest output buffer
    assign w_out_take  = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_buf[r_out_cnt];
    assign o_out_last  = (r_out_cnt == FILL_W'(BLOCK_BYTES - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.digest) begin
            r_out_buf <= r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_cnt   <= '0;
        end else if (i_cmd.digest) begin
            r_out_valid <= 1'b1;
            r_out_cnt   <= '0;
        end else if (w_out_take) begin
            r_out_cnt <= r_out_cnt + FILL_W'(1);
            if (o_out_last) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Round steps never run past the last round
    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_rnd < RND_W'(md2vh_pkg::ROUNDS)))
        else $error("round counter past last round");

    // A new digest never overwrites one still draining
    a_digest_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.digest |-> !r_out_valid)
        else $error("digest handed over while output busy");

    // State and checksum start the next message cleared
    a_digest_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.digest |=> (r_state == '0) && (r_cks == '0) && (r_fill == '0) && r_out_valid)
        else $error("state not cleared after digest");

endmodule

### rtl/md2_variant_byte_hash.sv
// Top level of the byte-stream MD2-style digest block.
//
//  channel   dir  handshake                      payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata=message_byte, tuser=byte_present,
//                                                  tlast=end_of_message
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata=digest_byte, tlast=digest_last
//
// A byte that neither completes a block nor ends the message leaves the input ready. A byte
// that completes a block holds the input off for load, 18 rounds of 48 serial table steps
// through the one lookup on the rotating work array, commit and 16 checksum steps.
// An end item adds a pad step and the same sequence for the pad block, then the final
// compression of the checksum and, once the output buffer is free, the digest hand-off.
// Reset clears state, checksum and counters at once; no sweep is needed.
// The 16 digest bytes drain from their own buffer while the next message is taken.
`timescale 1ns / 1ps

module md2_variant_byte_hash #(
    parameter int BLOCK_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] message_byte
    input  logic [0:0] i_s_axis_tuser,   // [0] byte_present
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] digest_byte
    output logic       o_m_axis_tlast
);

    md2vh_pkg::t_dp_cmd    w_cmd;
    md2vh_pkg::t_dp_status w_status;

    md2vh_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_present (i_s_axis_tuser[0]),
        .i_in_end     (i_s_axis_tlast),
        .o_in_ready   (o_s_axis_tready),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    md2vh_dp #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_byte      (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_byte  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule
